/* design/sctm_pkg.sv */
// Shared types and constants of the sensor channel scale and threshold monitor.
// Used by sensor_channel_scale_threshold_monitor and its testbench; depends on nothing else.
`default_nettype none

package sctm_pkg;

   // Quotient bits produced by the shift-subtract divider, one per cycle.
   localparam int unsigned DivSteps = 48;
   localparam int unsigned DivCntWidth = $clog2(DivSteps);

   typedef enum logic [2:0] {
      EVENT_READING   = 3'd0,
      EVENT_RECOVERED = 3'd1,
      EVENT_HIGH      = 3'd2,
      EVENT_LOW       = 3'd3,
      EVENT_FAULT     = 3'd4
   } event_kind_type;

   typedef enum logic [2:0] {
      REG_ENABLE    = 3'd0,
      REG_PERIOD    = 3'd1,
      REG_NUMERATOR = 3'd2,
      REG_DENOM     = 3'd3,
      REG_OFFSET    = 3'd4,
      REG_HIGH      = 3'd5,
      REG_LOW       = 3'd6,
      REG_BYPASS    = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ABS,
      ST_DIV,
      ST_NEG,
      ST_SUM,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               read_ok;
      logic signed [31:0] raw_sample;
   } req_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic signed [31:0] value;
      logic [7:0]         error_tally;
      logic [31:0]        stamp_ms;
      logic               last_of_run;
   } rsp_type;

   // Results still owed for the current item, in emission order.
   typedef struct packed {
      logic fault;
      logic rec;
      logic reading;
      logic high;
      logic low;
   } pend_type;

endpackage

`default_nettype wire

/* design/sensor_channel_scale_threshold_monitor.sv */
// A scaled item goes from acceptance through one multiply, one magnitude step, 48 divider
// steps (one quotient bit per cycle), then sign, offset/saturate and alarm decision steps,
// and then emits its results one at a time, each as the result register can load.
// One item is in work at a time: no new tick is taken until its last result is loaded;
// pass-through items skip the scaling steps, fault items go straight to emission.
// Reset is synchronous: configuration returns to its defaults and all channel state clears.
`default_nettype none

module sensor_channel_scale_threshold_monitor (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire sctm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output sctm_pkg::rsp_type      rsp_data,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [4:0]             paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import sctm_pkg::*;

   // Configuration registers.
   logic               enable_ff;
   logic [31:0]        period_ff;
   logic signed [15:0] num_ff;
   logic [15:0]        den_ff;
   logic signed [31:0] offset_ff;
   logic signed [31:0] high_ff;
   logic signed [31:0] low_ff;
   logic               bypass_ff;

   // Channel state.
   logic [31:0] last_time_ff, last_time_in;
   logic [7:0]  err_ff, err_in;
   logic        fault_ff, fault_in;
   logic        high_act_ff, high_act_in;
   logic        low_act_ff, low_act_in;

   // Work registers.
   state_type               state_ff, state_in;
   logic [31:0]             stamp_ff, stamp_in;
   logic signed [31:0]      raw_ff, raw_in;
   logic signed [47:0]      prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic [47:0]             quo_ff, quo_in;
   logic [15:0]             rem_ff, rem_in;
   logic [DivCntWidth-1:0]  cnt_ff, cnt_in;
   logic signed [48:0]      sq_ff, sq_in;
   logic signed [31:0]      value_ff, value_in;
   pend_type                pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic          cfg_write;
   reg_index_type cfg_idx;
   logic [31:0]   elapsed;
   logic          take;
   logic          pass_through;
   logic          load;
   logic [16:0]   trial;
   logic signed [49:0] sum;
   pend_type      pick;
   pend_type      rest;

   assign pready    = 1'b1;
   assign cfg_idx   = reg_index_type'(paddr[4:2]);
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      unique case (cfg_idx)
         REG_ENABLE:    prdata = {31'd0, enable_ff};
         REG_PERIOD:    prdata = period_ff;
         REG_NUMERATOR: prdata = {16'd0, num_ff};
         REG_DENOM:     prdata = {16'd0, den_ff};
         REG_OFFSET:    prdata = offset_ff;
         REG_HIGH:      prdata = high_ff;
         REG_LOW:       prdata = low_ff;
         REG_BYPASS:    prdata = {31'd0, bypass_ff};
      endcase
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign elapsed      = req_data.now_ms - last_time_ff;
   assign take         = enable_ff && (elapsed >= period_ff);
   assign pass_through = bypass_ff || (den_ff == 16'd0);
   assign load         = !rsp_valid_ff || rsp_ready;
   assign trial        = {rem_ff, quo_ff[47]};
   assign sum          = 50'(sq_ff) + 50'(offset_ff);

   // Fixed emission order: fault, recovery, reading, high alarm, low alarm.
   always_comb begin
      pick = '0;
      priority if (pend_ff.fault) begin
         pick.fault = 1'b1;
      end else if (pend_ff.rec) begin
         pick.rec = 1'b1;
      end else if (pend_ff.reading) begin
         pick.reading = 1'b1;
      end else if (pend_ff.high) begin
         pick.high = 1'b1;
      end else if (pend_ff.low) begin
         pick.low = 1'b1;
      end else begin
         pick = '0;
      end
   end
   assign rest = pend_ff & ~pick;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && take) begin
               if (!req_data.read_ok) begin
                  state_in = ST_EMIT;
               end else if (pass_through) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL:    state_in = ST_ABS;
         ST_ABS:    state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DivCntWidth'(DivSteps - 1)) begin
               state_in = ST_NEG;
            end
         end
         ST_NEG:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (load && (rest == '0)) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      last_time_in = last_time_ff;
      err_in       = err_ff;
      fault_in     = fault_ff;
      high_act_in  = high_act_ff;
      low_act_in   = low_act_ff;
      stamp_in     = stamp_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      sq_in        = sq_ff;
      value_in     = value_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && take) begin
               last_time_in = req_data.now_ms;
               stamp_in     = req_data.now_ms;
               raw_in       = req_data.raw_sample;
               value_in     = req_data.raw_sample;
               pend_in      = '0;
               if (!req_data.read_ok) begin
                  err_in        = err_ff + 8'd1;
                  fault_in      = 1'b1;
                  pend_in.fault = 1'b1;
               end
            end
         end
         ST_MUL: begin
            prod_in = raw_ff * num_ff;
         end
         ST_ABS: begin
            neg_in = prod_ff[47];
            quo_in = prod_ff[47] ? 48'(-prod_ff) : 48'(prod_ff);
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            // Restoring division: the dividend shifts out of quo as quotient bits shift in.
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 16'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff + DivCntWidth'(1);
         end
         ST_NEG: begin
            sq_in = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
         end
         ST_SUM: begin
            if (sum[49:31] == {19{sum[49]}}) begin
               value_in = sum[31:0];
            end else if (sum[49]) begin
               value_in = 32'sh8000_0000;
            end else begin
               value_in = 32'sh7FFF_FFFF;
            end
         end
         ST_DECIDE: begin
            pend_in.reading = 1'b1;
            if (fault_ff) begin
               pend_in.rec = 1'b1;
               fault_in    = 1'b0;
               err_in      = '0;
            end
            if (high_ff != 32'sd0) begin
               if (!high_act_ff && (value_ff >= high_ff)) begin
                  high_act_in  = 1'b1;
                  pend_in.high = 1'b1;
               end else if (high_act_ff && (value_ff < high_ff)) begin
                  high_act_in = 1'b0;
               end
            end
            if (low_ff != 32'sd0) begin
               if (!low_act_ff && (value_ff <= low_ff)) begin
                  low_act_in  = 1'b1;
                  pend_in.low = 1'b1;
               end else if (low_act_ff && (value_ff > low_ff)) begin
                  low_act_in = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in        = 1'b1;
               pend_in             = rest;
               rsp_in.value        = pick.fault ? 32'sd0 : value_ff;
               rsp_in.error_tally  = pick.fault ? err_ff : 8'd0;
               rsp_in.stamp_ms     = stamp_ff;
               rsp_in.last_of_run  = (rest == '0);
               priority if (pick.fault) begin
                  rsp_in.event_kind = EVENT_FAULT;
               end else if (pick.rec) begin
                  rsp_in.event_kind = EVENT_RECOVERED;
               end else if (pick.reading) begin
                  rsp_in.event_kind = EVENT_READING;
               end else if (pick.high) begin
                  rsp_in.event_kind = EVENT_HIGH;
               end else begin
                  rsp_in.event_kind = EVENT_LOW;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         period_ff    <= '0;
         num_ff       <= 16'sd1;
         den_ff       <= 16'd1;
         offset_ff    <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         bypass_ff    <= 1'b0;
         last_time_ff <= '0;
         err_ff       <= '0;
         fault_ff     <= 1'b0;
         high_act_ff  <= 1'b0;
         low_act_ff   <= 1'b0;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            unique case (cfg_idx)
               REG_ENABLE:    enable_ff <= pwdata[0];
               REG_PERIOD:    period_ff <= pwdata;
               REG_NUMERATOR: num_ff    <= pwdata[15:0];
               REG_DENOM:     den_ff    <= pwdata[15:0];
               REG_OFFSET:    offset_ff <= pwdata;
               REG_HIGH:      high_ff   <= pwdata;
               REG_LOW:       low_ff    <= pwdata;
               REG_BYPASS:    bypass_ff <= pwdata[0];
            endcase
         end
         last_time_ff <= last_time_in;
         err_ff       <= err_in;
         fault_ff     <= fault_in;
         high_act_ff  <= high_act_in;
         low_act_ff   <= low_act_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stamp_ff <= stamp_in;
      raw_ff   <= raw_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      sq_ff    <= sq_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

/* dv/sensor_channel_scale_threshold_monitor_tb.sv */
// Self-checking testbench of the sensor channel scale and threshold monitor: directed and
// random ticks go through a valid/ready driver, and every result is checked against a predictor.
// Depends on sctm_pkg and the block's RTL only.

module sensor_channel_scale_threshold_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sctm_pkg::*;

   typedef struct {
      req_type tick;
      bit      drain_first;
   } pending_tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Channel configuration as the block should hold it.
   bit                 cfg_enabled = 1'b0;
   logic [31:0]        cfg_period = '0;
   logic signed [15:0] cfg_num = 16'sd1;
   logic [15:0]        cfg_den = 16'd1;
   logic signed [31:0] cfg_offset = '0;
   logic signed [31:0] cfg_high = '0;
   logic signed [31:0] cfg_low = '0;
   bit                 cfg_bypass = 1'b0;

   // Channel state as the block should hold it.
   logic [31:0] last_time = '0;
   logic [7:0]  err_count = '0;
   bit          in_fault = 1'b0;
   bit          high_on = 1'b0;
   bit          low_on = 1'b0;

   rsp_type          expected_events[$];
   pending_tick_type pending_ticks[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               mismatch_total = 0;
   logic [31:0]      tick_now = '0;

   sensor_channel_scale_threshold_monitor dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type make_event(event_kind_type kind, logic [31:0] val,
                                          logic [7:0] tally, logic [31:0] stamp);
      rsp_type ev;
      ev.event_kind  = kind;
      ev.value       = val;
      ev.error_tally = tally;
      ev.stamp_ms    = stamp;
      ev.last_of_run = 1'b0;
      return ev;
   endfunction

   // Works out the results of one accepted tick and appends them to expected_events.
   function automatic void predict_tick(req_type t);
      logic [31:0]        elapsed;
      longint             raw_l;
      longint             num_l;
      longint             den_l;
      longint             off_l;
      longint             scaled;
      logic signed [31:0] val;
      rsp_type            burst[4];
      int                 n;
      n = 0;
      elapsed = t.now_ms - last_time;
      if (!cfg_enabled || elapsed < cfg_period) begin
         return;
      end
      last_time = t.now_ms;
      if (!t.read_ok) begin
         err_count = err_count + 8'd1;
         in_fault = 1'b1;
         burst[n++] = make_event(EVENT_FAULT, '0, err_count, t.now_ms);
      end else begin
         if (cfg_bypass || cfg_den == 16'd0) begin
            val = t.raw_sample;
         end else begin
            raw_l = $signed(t.raw_sample);
            num_l = cfg_num;
            den_l = cfg_den;
            off_l = cfg_offset;
            scaled = raw_l * num_l / den_l + off_l;
            if (scaled > 64'sd2147483647) begin
               scaled = 64'sd2147483647;
            end
            if (scaled < -64'sd2147483648) begin
               scaled = -64'sd2147483648;
            end
            val = scaled[31:0];
         end
         if (in_fault) begin
            in_fault = 1'b0;
            err_count = '0;
            burst[n++] = make_event(EVENT_RECOVERED, val, '0, t.now_ms);
         end
         burst[n++] = make_event(EVENT_READING, val, '0, t.now_ms);
         // Alarms fire on the rising edge only; a zero threshold leaves the active bit alone.
         if (cfg_high != 0) begin
            if (!high_on && val >= cfg_high) begin
               high_on = 1'b1;
               burst[n++] = make_event(EVENT_HIGH, val, '0, t.now_ms);
            end else if (high_on && val < cfg_high) begin
               high_on = 1'b0;
            end
         end
         if (cfg_low != 0) begin
            if (!low_on && val <= cfg_low) begin
               low_on = 1'b1;
               burst[n++] = make_event(EVENT_LOW, val, '0, t.now_ms);
            end else if (low_on && val > cfg_low) begin
               low_on = 1'b0;
            end
         end
      end
      burst[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) begin
         expected_events.push_back(burst[i]);
      end
   endfunction

   always @(posedge clock) begin : drive_ticks
      pending_tick_type next_tick;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_tick(req_data);
         end
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() != 0
                && !(pending_ticks[0].drain_first && expected_events.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               next_tick = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_data <= next_tick.tick;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $error("unexpected result: event_kind %0d value %0d stamp_ms %0h",
                   rsp_data.event_kind, rsp_data.value, rsp_data.stamp_ms);
            mismatch_total++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_data.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, actual %0d", want.event_kind,
                      rsp_data.event_kind);
               mismatch_total++;
            end
            if (rsp_data.value !== want.value) begin
               $error("value: expected %0d, actual %0d", want.value, rsp_data.value);
               mismatch_total++;
            end
            if (rsp_data.error_tally !== want.error_tally) begin
               $error("error_tally: expected %0d, actual %0d", want.error_tally,
                      rsp_data.error_tally);
               mismatch_total++;
            end
            if (rsp_data.stamp_ms !== want.stamp_ms) begin
               $error("stamp_ms: expected %0h, actual %0h", want.stamp_ms, rsp_data.stamp_ms);
               mismatch_total++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                      rsp_data.last_of_run);
               mismatch_total++;
            end
         end
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_ENABLE:    cfg_enabled = data[0];
         REG_PERIOD:    cfg_period = data;
         REG_NUMERATOR: cfg_num = data[15:0];
         REG_DENOM:     cfg_den = data[15:0];
         REG_OFFSET:    cfg_offset = data;
         REG_HIGH:      cfg_high = data;
         REG_LOW:       cfg_low = data;
         REG_BYPASS:    cfg_bypass = data[0];
         default:       ;
      endcase
   endtask

   // Waits until every item is out and answered, then lets a gated tick or a
   // scaled item still in the divider finish before anything is reconfigured.
   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_valid || expected_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (80) @(negedge clock);
   endtask

   function automatic void add_tick(logic [31:0] now, bit ok, logic [31:0] raw,
                                    bit drain_first = 1'b0);
      pending_tick_type e;
      e.tick.now_ms = now;
      e.tick.read_ok = ok;
      e.tick.raw_sample = raw;
      e.drain_first = drain_first;
      pending_ticks.push_back(e);
   endfunction

   // Mostly small and medium values, with full-range words and the 32-bit extremes mixed in.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0, 1, 2, 3: return int'($urandom_range(10000)) - 5000;
         4, 5:       return int'($urandom_range(2097152)) - 1048576;
         6, 7:       return $urandom;
         default: begin
            case ($urandom_range(4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
      endcase
   endfunction

   task automatic setup_random_config(input bit keep_enabled);
      logic [31:0] word;
      bit          en;
      en = keep_enabled || ($urandom_range(9) != 0);
      csr_write(REG_ENABLE, ($urandom & 32'hFFFF_FFFE) | en);
      case ($urandom_range(9))
         0:          word = $urandom;
         1, 2:       word = $urandom_range(50, 6);
         default:    word = $urandom_range(5);
      endcase
      csr_write(REG_PERIOD, word);
      case ($urandom_range(9))
         0:          word = 32'h0000_8000;
         1:          word = 32'h0000_7FFF;
         2, 3, 4:    word = $urandom;
         default:    word = int'($urandom_range(40)) - 20;
      endcase
      csr_write(REG_NUMERATOR, word);
      case ($urandom_range(9))
         0, 1:       word = 32'h0000_0000;
         2:          word = 32'h0000_FFFF;
         3, 4:       word = $urandom;
         default:    word = $urandom_range(100, 1);
      endcase
      csr_write(REG_DENOM, word);
      csr_write(REG_OFFSET, ($urandom_range(1) == 0) ? pick_word()
                                                     : int'($urandom_range(2000)) - 1000);
      csr_write(REG_HIGH, ($urandom_range(4) == 0) ? 32'h0 : pick_word());
      csr_write(REG_LOW, ($urandom_range(4) == 0) ? 32'h0 : pick_word());
      csr_write(REG_BYPASS, ($urandom & 32'hFFFF_FFFE) | ($urandom_range(4) == 0));
   endtask

   // Advances the tick clock, usually far enough to pass the period gate.
   function automatic void queue_random_tick(bit drain_first, bit force_fault);
      logic [31:0] step;
      if ($urandom_range(9) == 0) begin
         step = $urandom_range(cfg_period);
      end else if (cfg_period > 32'hFFFF_FFFC) begin
         step = cfg_period;
      end else begin
         step = cfg_period + $urandom_range(3);
      end
      tick_now = tick_now + step;
      add_tick(tick_now, !force_fault && $urandom_range(99) >= 12, pick_word(), drain_first);
   endfunction

   initial begin : stimulus
      int hold_at;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the channel is disabled and every tick is dropped.
      add_tick(32'd10, 1'b1, 32'd5);
      add_tick(32'd20, 1'b0, 32'd0);
      wait_idle();

      csr_write(REG_ENABLE, 32'd1);
      csr_write(REG_PERIOD, 32'd0);
      csr_write(REG_NUMERATOR, 32'd3);
      csr_write(REG_DENOM, 32'd2);
      csr_write(REG_OFFSET, -32'sd50);
      csr_write(REG_HIGH, 32'd1000);
      csr_write(REG_LOW, -32'sd1000);
      csr_write(REG_BYPASS, 32'd0);
      add_tick(32'd100, 1'b1, 32'd0);
      add_tick(32'd101, 1'b1, 32'd2000);
      add_tick(32'd102, 1'b1, 32'd2000);
      add_tick(32'd103, 1'b1, 32'd100);
      add_tick(32'd104, 1'b1, -32'sd1000);
      add_tick(32'd105, 1'b0, 32'h1234_5678);
      add_tick(32'd106, 1'b0, 32'd0);
      add_tick(32'd107, 1'b1, 32'd500);
      add_tick(32'd108, 1'b1, -32'sd7);
      add_tick(32'd109, 1'b1, 32'h7FFF_FFFF);
      add_tick(32'd110, 1'b1, 32'h8000_0000);
      add_tick(32'd111, 1'b1, 32'd2000);
      wait_idle();

      // Zero thresholds freeze the alarm bits while the scale overflows both ways.
      csr_write(REG_HIGH, 32'd0);
      csr_write(REG_LOW, 32'd0);
      csr_write(REG_NUMERATOR, 32'h0000_8000);
      csr_write(REG_DENOM, 32'd1);
      csr_write(REG_OFFSET, 32'h7FFF_FFFF);
      add_tick(32'd200, 1'b1, 32'h8000_0000);
      add_tick(32'd201, 1'b1, 32'd1);
      add_tick(32'd202, 1'b1, 32'h7FFF_FFFF);
      wait_idle();

      // Bypass with a period, across the wrap of the tick clock.
      csr_write(REG_HIGH, 32'd1000);
      csr_write(REG_NUMERATOR, 32'h0000_7FFF);
      csr_write(REG_DENOM, 32'h0000_FFFF);
      csr_write(REG_OFFSET, 32'h8000_0000);
      csr_write(REG_BYPASS, 32'd1);
      csr_write(REG_PERIOD, 32'd100);
      add_tick(32'd310, 1'b1, 32'd5000);
      add_tick(32'd360, 1'b1, 32'd1);
      add_tick(32'd410, 1'b1, -32'sd3);
      add_tick(32'hFFFF_FFF0, 1'b1, 32'h7FFF_FFFF);
      add_tick(32'h0000_0050, 1'b1, 32'd9);
      add_tick(32'h0000_0054, 1'b1, 32'hFFFF_FFFF);
      wait_idle();

      // A zero denominator passes the raw sample through without the offset.
      csr_write(REG_BYPASS, 32'd0);
      csr_write(REG_DENOM, 32'd0);
      csr_write(REG_PERIOD, 32'hFFFF_FFFF);
      add_tick(32'h0000_0060, 1'b1, 32'd77);
      add_tick(32'h0000_0053, 1'b1, 32'd77);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         setup_random_config(p == 2);
         if ($urandom_range(3) == 0) begin
            tick_now = 32'hFFFF_FFC0 + $urandom_range(63);
         end else begin
            tick_now = $urandom;
         end
         hold_at = $urandom_range(23);
         for (int k = 0; k < 24; k++) begin
            // A run of read errors counts up the error tally before a recovery.
            if (p == 2 && k == 8) begin
               for (int j = 0; j < 5; j++) begin
                  queue_random_tick(1'b0, 1'b1);
               end
            end
            queue_random_tick(k == hold_at, 1'b0);
         end
         wait_idle();
      end

      if (mismatch_total == 0 && expected_events.size() == 0) begin
         $display("** sensor_channel_scale_threshold_monitor: PASSED **");
      end else begin
         $display("** sensor_channel_scale_threshold_monitor: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("** sensor_channel_scale_threshold_monitor: FAILED **");
      $finish;
   end

endmodule

/* sensor_channel_scale_threshold_monitor.f */
design/sctm_pkg.sv
design/sensor_channel_scale_threshold_monitor.sv
dv/sensor_channel_scale_threshold_monitor_tb.sv
